// File: sv/sbrbc_pkg.sv
`default_nettype none
package sbrbc_pkg;

  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_DEPTH = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BLOCK_W    = 64;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_LOAD    = 2'd0;
  localparam cmd_code_t CMD_ENCRYPT = 2'd1;
  localparam cmd_code_t CMD_DECRYPT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic tbl_we;    // write forward and inverse entry from the input word
    logic start;     // latch block and direction
    logic first;     // round address comes from the latched block
    logic rd_en;     // issue one round of table reads
    logic out_load;  // capture final block into the result register
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// File: sv/sbrbc_ram.sv
`default_nettype none
module sbrbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/sbrbc_ctrl.sv
`default_nettype none
module sbrbc_ctrl #(
  parameter int unsigned ROUNDS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  input  wire sbrbc_pkg::cmd_code_t  command,
  output      logic                  item_ready,
  output      logic                  result_valid,
  input  wire logic                  result_ready,
  output      sbrbc_pkg::ctrl_cmd_t  cmd
);
  import sbrbc_pkg::*;

  localparam int unsigned CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  state_t           state, state_next;
  logic [CNT_W-1:0] round_cnt;
  logic             accept;
  logic             cipher_op;
  logic             last_round;
  logic             out_free;

  assign accept     = item_valid && item_ready;
  assign cipher_op  = (command == CMD_ENCRYPT) || (command == CMD_DECRYPT);
  assign last_round = (round_cnt == CNT_W'(ROUNDS - 1));
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cipher_op) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (last_round) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready   = 1'b1;
        cmd.tbl_we   = item_valid && (command == CMD_LOAD);
        cmd.start    = item_valid && cipher_op;
      end
      ST_ROUND: begin
        cmd.rd_en    = 1'b1;
        cmd.first    = (round_cnt == '0);
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      round_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) begin
        round_cnt <= last_round ? '0 : round_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/sbrbc_dp.sv
`default_nettype none
module sbrbc_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sbrbc_pkg::ctrl_cmd_t  cmd,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [63:0]           cipher_key,
  input  wire sbrbc_pkg::cmd_code_t  command,
  input  wire logic [63:0]           data_block,
  input  wire logic [2:0]            table_select,
  input  wire logic [7:0]            entry_index,
  input  wire logic [7:0]            entry_value,
  output      logic [63:0]           result_block
);
  import sbrbc_pkg::*;

  logic [BLOCK_W-1:0] key;
  logic [BLOCK_W-1:0] blk;
  logic               dec;
  logic [BYTE_W-1:0]  fwd_q [NUM_BANKS];
  logic [BYTE_W-1:0]  inv_q [NUM_BANKS];
  logic [BLOCK_W-1:0] q_word;
  logic [BLOCK_W-1:0] post;
  logic [BLOCK_W-1:0] cur;
  logic [BLOCK_W-1:0] pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key <= cipher_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk <= data_block;
      dec <= (command == CMD_DECRYPT);
    end
    if (cmd.out_load) begin
      result_block <= post;
    end
  end

  // byte 0 sits in the top byte
  always_comb begin
    for (int j = 0; j < NUM_BANKS; j++) begin
      q_word[BLOCK_W-1-BYTE_W*j -: BYTE_W] = dec ? inv_q[j] : fwd_q[j];
    end
  end

  // encrypt: key xor before lookup, rotate left after
  // decrypt: rotate right before lookup, key xor after
  assign post = dec ? (q_word ^ key) : {q_word[BLOCK_W-2:0], q_word[BLOCK_W-1]};
  assign cur  = cmd.first ? blk : post;
  assign pre  = dec ? {cur[0], cur[BLOCK_W-1:1]} : (cur ^ key);

  for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
    logic bank_we;
    assign bank_we = cmd.tbl_we && (table_select == 3'(j));

    sbrbc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_fwd (
      .clk   (clk),
      .we    (bank_we),
      .waddr (entry_index),
      .wdata (entry_value),
      .re    (cmd.rd_en && !dec),
      .raddr (pre[BLOCK_W-1-BYTE_W*j -: BYTE_W]),
      .rdata (fwd_q[j])
    );

    sbrbc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_inv (
      .clk   (clk),
      .we    (bank_we),
      .waddr (entry_value),
      .wdata (entry_index),
      .re    (cmd.rd_en && dec),
      .raddr (pre[BLOCK_W-1-BYTE_W*j -: BYTE_W]),
      .rdata (inv_q[j])
    );
  end

endmodule
`default_nettype wire

// File: sv/sbox_rotate_block_cipher_unit.sv
// Table load: one word per cycle while idle, written at acceptance, no result.
// Encrypt/decrypt: table reads run one round per cycle (eight byte banks read
// in parallel), then a capture state waits for a free output; result_valid
// rises after the capture, and the next word is accepted back in idle.
// Reset (rst, synchronous): controller idle, no result pending, key cleared;
// table contents are not cleared and must be loaded before use.
`default_nettype none
module sbox_rotate_block_cipher_unit #(
  parameter int unsigned ROUNDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [63:0] cipher_key,
  input  wire logic        item_valid,
  output      logic        item_ready,
  input  wire logic [1:0]  command,
  input  wire logic [63:0] data_block,
  input  wire logic [2:0]  table_select,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  entry_value,
  output      logic        result_valid,
  input  wire logic        result_ready,
  output      logic [63:0] result_block
);
  import sbrbc_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sbrbc_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .command      (command),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  sbrbc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cipher_key   (cipher_key),
    .command      (command),
    .data_block   (data_block),
    .table_select (table_select),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .result_block (result_block)
  );

endmodule
`default_nettype wire

// File: sv/sbrbc_checker.sv
`default_nettype none
module sbrbc_checker #(
  parameter int unsigned ROUNDS = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic [1:0]  command,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [63:0] result_block
);
  import sbrbc_pkg::*;

  logic cipher_accept;
  assign cipher_accept = item_valid && item_ready &&
                         ((command == CMD_ENCRYPT) || (command == CMD_DECRYPT));

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_block))
    else $error("result word changed or dropped while stalled");

  // busy while a block is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cipher_accept |=> !item_ready)
    else $error("new word accepted during cipher rounds");

  // with no result pending at acceptance, result_valid stays low through the rounds and the capture, then rises
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cipher_accept && !result_valid |-> ##(ROUNDS + 1) !result_valid ##1 result_valid)
    else $error("cipher result latency mismatch");

  // a fresh result appears only as the block returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("result raised while block busy");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("key write stalled");

endmodule

bind sbox_rotate_block_cipher_unit sbrbc_checker #(.ROUNDS(ROUNDS)) u_chk (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .command      (command),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_block (result_block)
);
`default_nettype wire

// File: test/sbox_rotate_block_cipher_unit_tb.sv
`default_nettype none
module sbox_rotate_block_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbrbc_pkg::*;

  localparam int unsigned CIPHER_ROUNDS = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_WORDS   = 400;
  localparam cmd_code_t   CMD_UNUSED    = 2'd3;

  // Expected-ciphertext tracker: mirrors key and both table sets, queues
  // the block each encrypt/decrypt word should produce.
  class cipher_tracker;
    bit [63:0]   round_key;
    bit [7:0]    fwd_sbox [NUM_BANKS*BANK_DEPTH];
    bit [7:0]    inv_sbox [NUM_BANKS*BANK_DEPTH];
    bit [63:0]   pending_blocks [$];
    int unsigned mismatches, checked;
    int unsigned n_encrypt, n_decrypt, n_load, n_ignored;

    function bit [63:0] substitute_bytes(bit [63:0] blk, bit use_inverse);
      bit [63:0] res;
      bit [7:0]  b_in;
      res = '0;
      for (int unsigned pos = 0; pos < NUM_BANKS; pos++) begin
        b_in = blk[63-8*pos -: 8];
        res[63-8*pos -: 8] = use_inverse ? inv_sbox[pos*BANK_DEPTH + b_in]
                                         : fwd_sbox[pos*BANK_DEPTH + b_in];
      end
      return res;
    endfunction

    function bit [63:0] encipher(bit [63:0] blk);
      for (int unsigned r = 0; r < CIPHER_ROUNDS; r++) begin
        blk = substitute_bytes(blk ^ round_key, 1'b0);
        blk = {blk[62:0], blk[63]};
      end
      return blk;
    endfunction

    function bit [63:0] decipher(bit [63:0] blk);
      for (int unsigned r = 0; r < CIPHER_ROUNDS; r++) begin
        blk = {blk[0], blk[63:1]};
        blk = substitute_bytes(blk, 1'b1) ^ round_key;
      end
      return blk;
    endfunction

    function void note_word(cmd_code_t cmd, bit [63:0] blk, bit [2:0] sel,
                            bit [7:0] idx, bit [7:0] val);
      case (cmd)
        CMD_LOAD: begin
          fwd_sbox[sel*BANK_DEPTH + idx] = val;
          inv_sbox[sel*BANK_DEPTH + val] = idx;
          n_load++;
        end
        CMD_ENCRYPT: begin
          pending_blocks.push_back(encipher(blk));
          n_encrypt++;
        end
        CMD_DECRYPT: begin
          pending_blocks.push_back(decipher(blk));
          n_decrypt++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_block(logic [63:0] got);
      bit [63:0] want;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        $display("%0t: result_block %h with no block outstanding", $time, got);
        return;
      end
      want = pending_blocks.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: result_block mismatch, expected %h actual %h", $time, want, got);
      end
    endfunction
  endclass

  cipher_tracker tracker = new;

  logic        clk;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [63:0] cipher_key   = '0;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  logic [1:0]  command      = CMD_LOAD;
  logic [63:0] data_block   = '0;
  logic [2:0]  table_select = '0;
  logic [7:0]  entry_index  = '0;
  logic [7:0]  entry_value  = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [63:0] result_block;

  bit [7:0]    sbox_img [NUM_BANKS][BANK_DEPTH];
  int unsigned send_calm, recv_calm, keys_used, quiet_cycles;

  sbox_rotate_block_cipher_unit #(.ROUNDS(CIPHER_ROUNDS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cipher_key   (cipher_key),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .data_block   (data_block),
    .table_select (table_select),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_block (result_block)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long, and runs with none at all
  function automatic int unsigned pick_idle(ref int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit [63:0] any_block();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {8{8'hA5}};
      3:       return 64'h8000_0000_0000_0001;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(cmd_code_t cmd, bit [63:0] blk, bit [2:0] sel,
                           bit [7:0] idx, bit [7:0] val);
    int unsigned gap;
    command      <= cmd;
    data_block   <= blk;
    table_select <= sel;
    entry_index  <= idx;
    entry_value  <= val;
    item_valid   <= 1'b1;
    do @(posedge clk); while (!item_ready);
    tracker.note_word(cmd, blk, sel, idx, val);
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(cmd_code_t cmd, bit [63:0] blk);
    send_word(cmd, blk, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic load_entry(bit [2:0] sel, bit [7:0] idx, bit [7:0] val);
    send_word(CMD_LOAD, {$urandom, $urandom}, sel, idx, val);
  endtask

  // encrypt then decrypt the predicted ciphertext, or the other way round
  task automatic round_trip(bit [63:0] blk, bit enc_first);
    if (enc_first) begin
      send_block(CMD_ENCRYPT, blk);
      send_block(CMD_DECRYPT, tracker.encipher(blk));
    end else begin
      send_block(CMD_DECRYPT, blk);
      send_block(CMD_ENCRYPT, tracker.decipher(blk));
    end
  endtask

  task automatic swap_entries();
    bit [2:0] t;
    bit [7:0] a, b, va;
    t  = 3'($urandom_range(0, 7));
    a  = 8'($urandom_range(0, 255));
    b  = a + 8'($urandom_range(1, 255));
    va = sbox_img[t][a];
    load_entry(t, a, sbox_img[t][b]);
    load_entry(t, b, va);
    sbox_img[t][a] = sbox_img[t][b];
    sbox_img[t][b] = va;
  endtask

  // break a table for a while: two entries share one value, so the inverse
  // entry follows the last load; then put the permutation back
  task automatic collide_entries();
    bit [2:0] t;
    bit [7:0] a, b;
    t = 3'($urandom_range(0, 7));
    a = 8'($urandom_range(0, 255));
    b = a + 8'($urandom_range(1, 255));
    load_entry(t, a, sbox_img[t][b]);
    send_block(CMD_ENCRYPT, any_block());
    send_block(CMD_DECRYPT, any_block());
    round_trip(any_block(), 1'($urandom_range(0, 1)));
    load_entry(t, a, sbox_img[t][a]);
    load_entry(t, b, sbox_img[t][b]);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_key(bit [63:0] k);
    drain();
    repeat (CIPHER_ROUNDS + 4) @(posedge clk);
    cipher_key <= k;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.round_key = k;
    keys_used++;
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned done, r, pause_at;
    bit paused;
    done     = 0;
    paused   = 1'b0;
    pause_at = $urandom_range(count / 4, 3 * count / 4);
    while (done < count) begin
      if (!paused && done >= pause_at) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 36) begin
        send_block(CMD_ENCRYPT, any_block());
        done += 1;
      end else if (r < 60) begin
        send_block(CMD_DECRYPT, any_block());
        done += 1;
      end else if (r < 80) begin
        round_trip(any_block(), 1'($urandom_range(0, 1)));
        done += 2;
      end else if (r < 93) begin
        swap_entries();
        done += 2;
      end else if (r < 96) begin
        collide_entries();
        done += 7;
      end else begin
        send_word(CMD_UNUSED, {$urandom, $urandom}, 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    bit [7:0]    tmp;
    int unsigned j;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_key('1);
    for (int unsigned t = 0; t < NUM_BANKS; t++) begin
      for (int unsigned i = 0; i < BANK_DEPTH; i++) sbox_img[t][i] = 8'(i);
      for (int unsigned i = BANK_DEPTH - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = sbox_img[t][i];
        sbox_img[t][i] = sbox_img[t][j];
        sbox_img[t][j] = tmp;
      end
      for (int unsigned i = 0; i < BANK_DEPTH; i++)
        load_entry(3'(t), 8'(i), sbox_img[t][i]);
    end

    send_block(CMD_ENCRYPT, '0);
    send_block(CMD_ENCRYPT, '1);
    send_block(CMD_ENCRYPT, 64'h8000_0000_0000_0001);
    send_block(CMD_DECRYPT, '0);
    send_block(CMD_DECRYPT, '1);
    send_block(CMD_DECRYPT, 64'h0123_4567_89AB_CDEF);
    round_trip(64'hDEAD_BEEF_0BAD_F00D, 1'b1);
    round_trip(64'hFEDC_BA98_7654_3210, 1'b0);
    send_word(CMD_UNUSED, '1, '1, '1, '1);
    send_word(CMD_UNUSED, '0, '0, '0, '0);
    collide_entries();

    write_key('0);
    random_phase(PHASE_WORDS);
    write_key({$urandom, $urandom});
    random_phase(PHASE_WORDS);
    write_key(64'h1);
    random_phase(PHASE_WORDS);
    write_key({$urandom, $urandom});
    random_phase(PHASE_WORDS);

    drain();
    repeat (CIPHER_ROUNDS + 8) @(posedge clk);
    $display("Ran %0d encrypt, %0d decrypt, %0d table-load and %0d unused-command words",
             tracker.n_encrypt, tracker.n_decrypt, tracker.n_load, tracker.n_ignored);
    $display("across %0d key settings; %0d result words compared, %0d mismatches",
             keys_used, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver: check on handshake, then pick ready for the next cycle
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) tracker.check_block(result_block);
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        stall = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, tracker.pending_blocks.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
